### hdl/tbm_pkg.sv
// tbm_pkg: shared widths, result kind codes, register indexes and the
// result record passed from the excursion tracker to the output register
// no dependencies
package tbm_pkg;

	localparam int TEMP_W  = 12;
	localparam int TIME_W  = 40;
	localparam int LIMIT_W = 32;
	localparam int COUNT_W = 32;
	localparam int KIND_W  = 2;
	localparam int INDEX_W = 1;
	localparam int DATA_W  = 32;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_READING  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALERT    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESTORED = 2'd2;

	// configuration register indexes
	localparam logic [INDEX_W-1:0] CFG_THRESHOLD = 1'b0;
	localparam logic [INDEX_W-1:0] CFG_LIMIT     = 1'b1;

	// register reset values
	localparam logic signed [TEMP_W-1:0] THRESHOLD_RST = 12'sd128;
	localparam logic [LIMIT_W-1:0]       LIMIT_RST     = 32'd30000;

	// everything one item produces, before sequence numbering
	typedef struct packed {
		logic                     has_extra;
		logic [KIND_W-1:0]        extra_kind;
		logic signed [TEMP_W-1:0] temp;
		logic [TIME_W-1:0]        time_ms;
		logic                     above;
		logic [TIME_W-1:0]        exc_ms;
		logic [COUNT_W-1:0]       alert_no;
		logic signed [TEMP_W-1:0] peak;
	} result_t;

endpackage

### hdl/tbm_in_stage.sv
// tbm_in_stage: input register for one sample item
// depends on tbm_pkg
module tbm_in_stage (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [tbm_pkg::TEMP_W-1:0] sample_temp,
	input  logic [tbm_pkg::TIME_W-1:0]        sample_time_ms,
	input  logic                              take,
	output logic                              valid_s1,
	output logic signed [tbm_pkg::TEMP_W-1:0] temp_s1,
	output logic [tbm_pkg::TIME_W-1:0]        time_s1
);

	// free when empty or when the held item moves on this cycle
	assign in_ready = !valid_s1 || take;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			temp_s1 <= sample_temp;
			time_s1 <= sample_time_ms;
		end
	end

endmodule

### hdl/tbm_core.sv
// tbm_core: configuration registers, excursion state and the per-item
// threshold, elapsed-time and alert decisions
// depends on tbm_pkg
module tbm_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tbm_pkg::INDEX_W-1:0]        cfg_index,
	input  logic [tbm_pkg::DATA_W-1:0]         cfg_data,
	input  logic signed [tbm_pkg::TEMP_W-1:0]  temp_s1,
	input  logic [tbm_pkg::TIME_W-1:0]         time_s1,
	input  logic                               take,
	output tbm_pkg::result_t                   res
);

	logic signed [tbm_pkg::TEMP_W-1:0] threshold_q;
	logic [tbm_pkg::LIMIT_W-1:0]       limit_q;
	logic                              active_q;
	logic [tbm_pkg::TIME_W-1:0]        start_q;
	logic signed [tbm_pkg::TEMP_W-1:0] peak_q;
	logic                              alert_sent_q;
	logic [tbm_pkg::COUNT_W-1:0]       breach_total_q;

	logic                              above;
	logic [tbm_pkg::TIME_W-1:0]        start_eff;
	logic [tbm_pkg::TIME_W-1:0]        elapsed;
	logic                              alert_prev;
	logic                              fire;
	logic                              restore;
	logic signed [tbm_pkg::TEMP_W-1:0] peak_new;
	logic [tbm_pkg::COUNT_W-1:0]       breach_next;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= tbm_pkg::THRESHOLD_RST;
			limit_q     <= tbm_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbm_pkg::CFG_THRESHOLD: threshold_q <= cfg_data[tbm_pkg::TEMP_W-1:0];
				tbm_pkg::CFG_LIMIT:     limit_q     <= cfg_data[tbm_pkg::LIMIT_W-1:0];
				default:                limit_q     <= limit_q;
			endcase
		end
	end

	// threshold test and elapsed time, saturating at zero
	assign above      = temp_s1 > threshold_q;
	assign start_eff  = active_q ? start_q : time_s1;
	assign elapsed    = (time_s1 >= start_eff) ? (time_s1 - start_eff) : '0;
	assign alert_prev = active_q && alert_sent_q;
	assign fire       = above && !alert_prev &&
		(elapsed >= {{(tbm_pkg::TIME_W-tbm_pkg::LIMIT_W){1'b0}}, limit_q});
	assign restore    = !above && active_q && alert_sent_q;
	assign breach_next = breach_total_q + 1'b1;

	// running peak of the open excursion
	always_comb begin
		if (!active_q || temp_s1 > peak_q) begin
			peak_new = temp_s1;
		end else begin
			peak_new = peak_q;
		end
	end

	// result record for the output register
	always_comb begin
		res.has_extra  = fire || restore;
		res.extra_kind = fire ? tbm_pkg::KIND_ALERT : tbm_pkg::KIND_RESTORED;
		res.temp       = temp_s1;
		res.time_ms    = time_s1;
		res.above      = above;
		res.exc_ms     = (above || restore) ? elapsed : '0;
		res.alert_no   = breach_next;
		res.peak       = peak_q;
	end

	// excursion state, updated as the item moves to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			start_q        <= '0;
			peak_q         <= '0;
			alert_sent_q   <= 1'b0;
			breach_total_q <= '0;
		end else if (take) begin
			if (above) begin
				active_q     <= 1'b1;
				start_q      <= start_eff;
				peak_q       <= peak_new;
				alert_sent_q <= alert_prev || fire;
				if (fire) begin
					breach_total_q <= breach_next;
				end
			end else if (active_q) begin
				active_q     <= 1'b0;
				start_q      <= '0;
				peak_q       <= '0;
				alert_sent_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/tbm_out_stage.sv
// tbm_out_stage: result register that sends the optional alert or restored
// item ahead of the reading, and numbers every result
// depends on tbm_pkg
module tbm_out_stage (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid_s1,
	input  tbm_pkg::result_t                   res,
	output logic                               take,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tbm_pkg::KIND_W-1:0]         event_kind,
	output logic signed [tbm_pkg::TEMP_W-1:0]  event_temp,
	output logic [tbm_pkg::TIME_W-1:0]         event_time_ms,
	output logic                               above_flag,
	output logic [tbm_pkg::TIME_W-1:0]         excursion_ms,
	output logic [tbm_pkg::COUNT_W-1:0]        alert_number,
	output logic signed [tbm_pkg::TEMP_W-1:0]  peak_temp,
	output logic [tbm_pkg::COUNT_W-1:0]        sequence_number,
	output logic                               last_flag
);

	logic             valid_s2;
	logic             extra_s2;
	tbm_pkg::result_t res_s2;
	logic [tbm_pkg::COUNT_W-1:0] seq_q;
	logic             out_fire;
	logic             is_alert;

	assign out_fire = valid_s2 && out_ready;
	// a new item loads once the last result of the held one leaves
	assign take     = valid_s1 && (!valid_s2 || (out_ready && !extra_s2));

	// occupancy and pending extra result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			extra_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= 1'b1;
			extra_s2 <= res.has_extra;
		end else if (out_fire) begin
			if (extra_s2) begin
				extra_s2 <= 1'b0;
			end else begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take) begin
			res_s2 <= res;
		end
	end

	// sequence count of delivered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (out_fire) begin
			seq_q <= seq_q + 1'b1;
		end
	end

	// result fields: extra item first, then the reading
	assign is_alert        = res_s2.extra_kind == tbm_pkg::KIND_ALERT;
	assign out_valid       = valid_s2;
	assign event_kind      = extra_s2 ? res_s2.extra_kind : tbm_pkg::KIND_READING;
	assign event_temp      = res_s2.temp;
	assign event_time_ms   = res_s2.time_ms;
	assign above_flag      = extra_s2 ? is_alert : res_s2.above;
	assign excursion_ms    = (extra_s2 || res_s2.above) ? res_s2.exc_ms : '0;
	assign alert_number    = (extra_s2 && is_alert) ? res_s2.alert_no : '0;
	assign peak_temp       = (extra_s2 && !is_alert) ? res_s2.peak : '0;
	assign sequence_number = seq_q;
	assign last_flag       = !extra_s2;

endmodule

### hdl/temperature_breach_monitor.sv
// temperature_breach_monitor: input register, excursion tracker, result register
// an accepted item waits in the input register until the result register takes it
// throughput: one result per cycle at the output while out_ready is high, so one item
// per cycle for a reading only; with an alert or restored it holds until both results leave
// reset: asynchronous active low; clears excursion state and counters, threshold 128, limit 30000
// depends on tbm_pkg, tbm_in_stage, tbm_core, tbm_out_stage
module temperature_breach_monitor (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tbm_pkg::INDEX_W-1:0]        cfg_index,
	input  logic [tbm_pkg::DATA_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [tbm_pkg::TEMP_W-1:0]  sample_temp,
	input  logic [tbm_pkg::TIME_W-1:0]         sample_time_ms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tbm_pkg::KIND_W-1:0]         event_kind,
	output logic signed [tbm_pkg::TEMP_W-1:0]  event_temp,
	output logic [tbm_pkg::TIME_W-1:0]         event_time_ms,
	output logic                               above_flag,
	output logic [tbm_pkg::TIME_W-1:0]         excursion_ms,
	output logic [tbm_pkg::COUNT_W-1:0]        alert_number,
	output logic signed [tbm_pkg::TEMP_W-1:0]  peak_temp,
	output logic [tbm_pkg::COUNT_W-1:0]        sequence_number,
	output logic                               last_flag
);

	logic                              valid_s1;
	logic signed [tbm_pkg::TEMP_W-1:0] temp_s1;
	logic [tbm_pkg::TIME_W-1:0]        time_s1;
	logic                              take;
	tbm_pkg::result_t                  res;

	// sample register
	tbm_in_stage u_in (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_temp    (sample_temp),
		.sample_time_ms (sample_time_ms),
		.take           (take),
		.valid_s1       (valid_s1),
		.temp_s1        (temp_s1),
		.time_s1        (time_s1)
	);

	// excursion tracking
	tbm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.temp_s1   (temp_s1),
		.time_s1   (time_s1),
		.take      (take),
		.res       (res)
	);

	// result register
	tbm_out_stage u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s1        (valid_s1),
		.res             (res),
		.take            (take),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_kind      (event_kind),
		.event_temp      (event_temp),
		.event_time_ms   (event_time_ms),
		.above_flag      (above_flag),
		.excursion_ms    (excursion_ms),
		.alert_number    (alert_number),
		.peak_temp       (peak_temp),
		.sequence_number (sequence_number),
		.last_flag       (last_flag)
	);

endmodule

### hdl/tbm_checker.sv
// tbm_checker: port-level checks on the result stream, bound to the top level
// depends on tbm_pkg
module tbm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [tbm_pkg::KIND_W-1:0]         event_kind,
	input logic [tbm_pkg::TIME_W-1:0]         event_time_ms,
	input logic                               above_flag,
	input logic [tbm_pkg::COUNT_W-1:0]        alert_number,
	input logic signed [tbm_pkg::TEMP_W-1:0]  peak_temp,
	input logic [tbm_pkg::COUNT_W-1:0]        sequence_number,
	input logic                               last_flag
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sequence_number) &&
		$stable(event_kind) && $stable(event_time_ms))
		else $error("result changed while stalled");

	// an extra item is followed at once by its reading, numbered next
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_flag |=> out_valid && last_flag &&
		event_kind == tbm_pkg::KIND_READING &&
		sequence_number == $past(sequence_number) + 1'b1 &&
		event_time_ms == $past(event_time_ms))
		else $error("extra item not followed by its reading");

	// the reading is always the last of an item and carries no alert or peak
	a_reading: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == tbm_pkg::KIND_READING |->
		last_flag && alert_number == '0 && peak_temp == '0)
		else $error("malformed reading");

	// restored items are never above threshold and never numbered as alerts
	a_restored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == tbm_pkg::KIND_RESTORED |->
		!above_flag && !last_flag && alert_number == '0)
		else $error("malformed restored item");

	// alerts are above threshold and precede the reading
	a_alert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == tbm_pkg::KIND_ALERT |->
		above_flag && !last_flag && peak_temp == '0)
		else $error("malformed alert");

endmodule

bind temperature_breach_monitor tbm_checker u_tbm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.event_kind      (event_kind),
	.event_time_ms   (event_time_ms),
	.above_flag      (above_flag),
	.alert_number    (alert_number),
	.peak_temp       (peak_temp),
	.sequence_number (sequence_number),
	.last_flag       (last_flag)
);

### sim/temperature_breach_monitor_test.sv
// temperature_breach_monitor_test: self-checking bench for the breach monitor,
// with an excursion tracker that predicts every result and random valid/ready idling
// depends on tbm_pkg and temperature_breach_monitor
module temperature_breach_monitor_test;
	timeunit 1ns;
	timeprecision 1ps;

	// sample temperature and the widest result field, for casts and compares
	typedef logic signed [tbm_pkg::TEMP_W-1:0] temp_t;
	typedef logic [tbm_pkg::TIME_W-1:0]        field_t;

	// one result as seen on the output port
	typedef struct {
		logic [tbm_pkg::KIND_W-1:0]        kind;
		logic signed [tbm_pkg::TEMP_W-1:0] temp;
		logic [tbm_pkg::TIME_W-1:0]        time_ms;
		logic                              above;
		logic [tbm_pkg::TIME_W-1:0]        exc_ms;
		logic [tbm_pkg::COUNT_W-1:0]       alert_no;
		logic signed [tbm_pkg::TEMP_W-1:0] peak;
		logic [tbm_pkg::COUNT_W-1:0]       seq;
		logic                              last;
	} monitor_result_t;

	// excursion tracker: predicts the results of each item and checks them in order
	class excursion_scoreboard;
		logic signed [tbm_pkg::TEMP_W-1:0] threshold;
		logic [tbm_pkg::LIMIT_W-1:0]       limit_ms;
		bit                                active;
		logic [tbm_pkg::TIME_W-1:0]        start_ms;
		logic signed [tbm_pkg::TEMP_W-1:0] peak;
		bit                                alerted;
		logic [tbm_pkg::COUNT_W-1:0]       breaches;
		logic [tbm_pkg::COUNT_W-1:0]       seq;
		monitor_result_t                   pending_events[$];
		int                                errors;

		function new();
			threshold = tbm_pkg::THRESHOLD_RST;
			limit_ms  = tbm_pkg::LIMIT_RST;
			active    = 0;
			start_ms  = '0;
			peak      = '0;
			alerted   = 0;
			breaches  = '0;
			seq       = '0;
			errors    = 0;
		endfunction

		function void write_config(logic [tbm_pkg::INDEX_W-1:0] idx,
				logic [tbm_pkg::DATA_W-1:0] value);
			if (idx == tbm_pkg::CFG_THRESHOLD) begin
				threshold = value[tbm_pkg::TEMP_W-1:0];
			end else if (idx == tbm_pkg::CFG_LIMIT) begin
				limit_ms = value;
			end
		endfunction

		function void push_result(logic [tbm_pkg::KIND_W-1:0] kind,
				logic signed [tbm_pkg::TEMP_W-1:0] temp,
				logic [tbm_pkg::TIME_W-1:0] now, logic above, logic [tbm_pkg::TIME_W-1:0] exc,
				logic [tbm_pkg::COUNT_W-1:0] alert_no, logic signed [tbm_pkg::TEMP_W-1:0] pk,
				logic last);
			monitor_result_t r;
			r.kind     = kind;
			r.temp     = temp;
			r.time_ms  = now;
			r.above    = above;
			r.exc_ms   = exc;
			r.alert_no = alert_no;
			r.peak     = pk;
			r.seq      = seq;
			r.last     = last;
			pending_events.push_back(r);
			seq++;
		endfunction

		// accepted sample: update excursion state, queue alert or restored, then the reading
		function void note_sample(logic signed [tbm_pkg::TEMP_W-1:0] temp,
				logic [tbm_pkg::TIME_W-1:0] now);
			logic [tbm_pkg::TIME_W-1:0] exc;
			logic [tbm_pkg::TIME_W-1:0] dur;
			bit                         above;
			above = temp > threshold;
			exc   = '0;
			if (above) begin
				if (!active) begin
					active   = 1;
					start_ms = now;
					peak     = temp;
					alerted  = 0;
				end else if (temp > peak) begin
					peak = temp;
				end
				// elapsed time saturates at zero when time runs backwards
				exc = (now >= start_ms) ? now - start_ms : '0;
				if (!alerted &&
						exc >= {{(tbm_pkg::TIME_W-tbm_pkg::LIMIT_W){1'b0}}, limit_ms}) begin
					alerted = 1;
					breaches++;
					push_result(tbm_pkg::KIND_ALERT, temp, now, 1'b1, exc, breaches, '0, 1'b0);
				end
			end else if (active) begin
				// excursion ends; restored only if it had alerted
				if (alerted) begin
					dur = (now >= start_ms) ? now - start_ms : '0;
					push_result(tbm_pkg::KIND_RESTORED, temp, now, 1'b0, dur, '0, peak, 1'b0);
				end
				active   = 0;
				start_ms = '0;
				peak     = '0;
				alerted  = 0;
			end
			push_result(tbm_pkg::KIND_READING, temp, now, above, exc, '0, '0, 1'b1);
		endfunction

		function void compare_field(string name, field_t want, field_t got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(monitor_result_t got);
			monitor_result_t want;
			if (pending_events.size() == 0) begin
				$error("result with no item pending: kind %0d seq %0d", got.kind, got.seq);
				errors++;
				return;
			end
			want = pending_events.pop_front();
			compare_field("event_kind", field_t'(want.kind), field_t'(got.kind));
			compare_field("event_temp", field_t'(want.temp), field_t'(got.temp));
			compare_field("event_time_ms", want.time_ms, got.time_ms);
			compare_field("above_flag", field_t'(want.above), field_t'(got.above));
			compare_field("excursion_ms", want.exc_ms, got.exc_ms);
			compare_field("alert_number", field_t'(want.alert_no), field_t'(got.alert_no));
			compare_field("peak_temp", field_t'(want.peak), field_t'(got.peak));
			compare_field("sequence_number", field_t'(want.seq), field_t'(got.seq));
			compare_field("last_flag", field_t'(want.last), field_t'(got.last));
		endfunction
	endclass

	// random phase settings, extremes included
	localparam int              THR_TABLE [6]   = '{128, -2048, 2047, 64, -1, 0};
	localparam logic [31:0]     LIMIT_TABLE [6] = '{32'd500, 32'd0, 32'd1000, 32'hFFFF_FFFF,
		32'd100, 32'd0};
	localparam logic [tbm_pkg::TIME_W-1:0] TIME_MAX = {tbm_pkg::TIME_W{1'b1}};

	logic                              clk             = 1'b0;
	logic                              arst_n          = 1'b0;
	logic                              cfg_we          = 1'b0;
	logic [tbm_pkg::INDEX_W-1:0]       cfg_index       = tbm_pkg::CFG_THRESHOLD;
	logic [tbm_pkg::DATA_W-1:0]        cfg_data        = '0;
	logic                              in_valid        = 1'b0;
	logic                              in_ready;
	logic signed [tbm_pkg::TEMP_W-1:0] sample_temp     = '0;
	logic [tbm_pkg::TIME_W-1:0]        sample_time_ms  = '0;
	logic                              out_valid;
	logic                              out_ready       = 1'b0;
	logic [tbm_pkg::KIND_W-1:0]        event_kind;
	logic signed [tbm_pkg::TEMP_W-1:0] event_temp;
	logic [tbm_pkg::TIME_W-1:0]        event_time_ms;
	logic                              above_flag;
	logic [tbm_pkg::TIME_W-1:0]        excursion_ms;
	logic [tbm_pkg::COUNT_W-1:0]       alert_number;
	logic signed [tbm_pkg::TEMP_W-1:0] peak_temp;
	logic [tbm_pkg::COUNT_W-1:0]       sequence_number;
	logic                              last_flag;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req      = 0;

	excursion_scoreboard tracker = new();

	temperature_breach_monitor dut (.*);

	always #2 clk = ~clk;

	// offer one item, with random idle cycles ahead of it
	task automatic send_sample(input int temp_c, input logic [tbm_pkg::TIME_W-1:0] ts);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		sample_temp    <= temp_t'(temp_c);
		sample_time_ms <= ts;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_sample(temp_t'(temp_c), ts);
	endtask

	// stop offering and wait until every expected result has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.pending_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tbm_pkg::INDEX_W-1:0] idx,
			input logic [tbm_pkg::DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		tracker.write_config(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// result side: random ready, long hold-offs on request, check every accepted result
	initial begin : result_sink
		monitor_result_t got;
		int              hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.kind     = event_kind;
				got.temp     = event_temp;
				got.time_ms  = event_time_ms;
				got.above    = above_flag;
				got.exc_ms   = excursion_ms;
				got.alert_no = alert_number;
				got.peak     = peak_temp;
				got.seq      = sequence_number;
				got.last     = last_flag;
				tracker.check_result(got);
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		int                         thr_i;
		int                         tv;
		int                         mode;
		int unsigned                step_max;
		int unsigned                pick;
		logic [31:0]                lim;
		logic [tbm_pkg::TIME_W-1:0] clock_ms;
		bit                         hot;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, excursion without alert, time going backwards, alert, restored
		send_sample(0, 40'd0);
		send_sample(-2048, 40'd0);
		send_sample(129, 40'd100);
		send_sample(200, 40'd10000);
		send_sample(150, 40'd5);
		send_sample(128, 40'd20000);
		send_sample(2047, 40'd20000);
		send_sample(300, 40'd50000);
		send_sample(500, 40'd60000);
		send_sample(0, 40'd70000);
		send_sample(2047, TIME_MAX);

		// zero limit: alert on the first sample above, restored with time going backwards
		wait_drained();
		write_reg(tbm_pkg::CFG_LIMIT, 32'd0);
		send_sample(1000, TIME_MAX);
		send_sample(-2048, 40'd0);
		send_sample(500, 40'd10);
		send_sample(129, 40'd20);
		send_sample(128, 40'd30);

		// lowest threshold
		wait_drained();
		write_reg(tbm_pkg::CFG_THRESHOLD, 32'hFFFF_F800);
		send_sample(-2048, 40'd5);
		send_sample(-2047, 40'd6);
		send_sample(-2048, 40'd7);

		// random phases: bursts above and below threshold with random content
		clock_ms = '0;
		hot      = 0;
		for (int p = 0; p < 6; p++) begin
			wait_drained();
			if (p == 5) begin
				thr_i = int'($urandom_range(4095)) - 2048;
				lim   = $urandom_range(5000);
			end else begin
				thr_i = THR_TABLE[p];
				lim   = LIMIT_TABLE[p];
			end
			write_reg(tbm_pkg::CFG_THRESHOLD, {20'($urandom), 12'(thr_i)});
			write_reg(tbm_pkg::CFG_LIMIT, lim);

			mode          = p / 2;
			send_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 59 : 0;
			recv_idle_pct = (mode == 0) ? 59 : (mode == 1) ? 24 : 0;
			step_max      = (lim == 0) ? 50 : (lim > 200000) ? 5000 : lim / 3 + 1;

			for (int i = 0; i < 330; i++) begin
				// output held off while items keep coming, later a full drain
				if (i == 100)
					hold_req = 300;
				if (i == 200)
					wait_drained();

				pick = $urandom_range(999);
				if (pick < 20)
					clock_ms = clock_ms - field_t'($urandom_range(2 * step_max));
				else if (pick < 30)
					clock_ms = field_t'({$urandom, $urandom});
				else if (pick < 40)
					clock_ms = clock_ms + field_t'({$urandom_range(3), $urandom});
				else
					clock_ms = clock_ms + field_t'($urandom_range(step_max));

				if ($urandom_range(99) < 12)
					hot = !hot;
				if ($urandom_range(99) < 8)
					tv = int'($signed(12'($urandom)));
				else if (hot)
					tv = thr_i + 1 + int'($urandom_range(60));
				else
					tv = thr_i - int'($urandom_range(60));
				if (tv > 2047)
					tv = 2047;
				if (tv < -2048)
					tv = -2048;

				send_sample(tv, clock_ms);
			end
		end

		// drain and report
		wait_drained();
		repeat (16) @(posedge clk);
		if (tracker.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// hang guard
	initial begin : watchdog
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### temperature_breach_monitor.f
hdl/tbm_pkg.sv
hdl/tbm_in_stage.sv
hdl/tbm_core.sv
hdl/tbm_out_stage.sv
hdl/temperature_breach_monitor.sv
hdl/tbm_checker.sv
sim/temperature_breach_monitor_test.sv
